/* sv/read_depth_coverage_accumulator_defines.svh */
// ----------------------------------------------------------------------------
// Read depth coverage accumulator: assertion macros
// Shared concurrent assertion forms for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef READ_DEPTH_COVERAGE_ACCUMULATOR_DEFINES_SVH
`define READ_DEPTH_COVERAGE_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDCA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rdca_pkg.sv */
// ----------------------------------------------------------------------------
// Read depth coverage accumulator package
// Sizes, register indexes, reset values and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rdca_pkg;

    // Site store geometry.
    localparam int MAX_SITES  = 1048576;
    localparam int SITE_AW    = $clog2(MAX_SITES);
    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Field widths.
    localparam int START_W  = 20;
    localparam int LEN_W    = 12;
    localparam int SUM_W    = 32;
    localparam int SITES_W  = 21;
    localparam int MEAN_W   = 24;
    localparam int TARGET_W = 24;
    localparam int REGION_W = 21;
    localparam int FRAC_W   = 8;

    // Width of site positions, clip bound and fragment end.
    localparam int LIM_W = (SITE_AW + 1 > REGION_W) ? SITE_AW + 1 : REGION_W;

    // Divider geometry: (sum << 8) / covered sites, one quotient bit a cycle.
    localparam int DIVD_W    = SUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    // Saturation values.
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SITES_W-1:0] SITES_MAX = {SITES_W{1'b1}};
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = {MEAN_W{1'b1}};

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_REGION = 1'b1;
    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1024);
    localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(1000000);

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DIV,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/rdca_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rdca_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/read_depth_coverage_accumulator.sv */
// Flow: start, a walk over the n sites the fragment covers after clipping to the region
// (0 to 4095), then the mean division, then the o_done strobe. A new fragment is taken
// only while busy is low; during the walk the site store does one read-modify-write per
// cycle, and the mean comes from a 40-step restoring divider.
// Reset: synchronous; afterwards a clearing pass zeroes the site store with busy high.
// Results cannot be stalled; the o_done strobe shows for one cycle only.
// ----------------------------------------------------------------------------
// Read depth coverage accumulator
// Adds each fragment to a per-site depth store and reports running totals,
// mean depth over covered sites and whether the target mean has been reached.
// ----------------------------------------------------------------------------
`default_nettype none

`include "read_depth_coverage_accumulator_defines.svh"

module read_depth_coverage_accumulator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rdca_pkg::START_W-1:0]   i_frag_start,
    input  wire logic [rdca_pkg::LEN_W-1:0]     i_frag_length,
    // Result channel
    output logic                                o_done,
    output logic      [rdca_pkg::SUM_W-1:0]     o_depth_sum,
    output logic      [rdca_pkg::SITES_W-1:0]   o_covered_sites,
    output logic      [rdca_pkg::MEAN_W-1:0]    o_mean_depth,
    output logic      [rdca_pkg::SUM_W-1:0]     o_fragment_count,
    output logic                                o_target_reached,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rdca_pkg::APB_AW-1:0]    paddr,
    input  wire logic [rdca_pkg::APB_DW-1:0]    pwdata,
    output logic      [rdca_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);

    import rdca_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);
    localparam logic [SITE_AW-1:0]   CLR_LAST = SITE_AW'(MAX_SITES - 1);

    // Controller state.
    t_state r_state, n_state;

    // Configuration registers.
    logic [TARGET_W-1:0] r_target;
    logic [REGION_W-1:0] r_region;

    // Running totals.
    logic [SUM_W-1:0]   r_total;
    logic [SITES_W-1:0] r_nonzero;
    logic [SUM_W-1:0]   r_frag;

    // Site walk.
    logic [LIM_W-1:0]   r_addr;
    logic [LIM_W-1:0]   r_end;
    logic               r_pend;
    logic [SITE_AW-1:0] r_waddr;
    logic [SITE_AW-1:0] r_clr;

    // Divider and result.
    logic [SITES_W-1:0]   r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MEAN_W-1:0]    r_mean;
    logic                 r_hit;

    // Combinational helpers.
    logic                  accept;
    logic                  cfg_wr;
    logic                  issue;
    logic                  walk_done;
    logic [LIM_W-1:0]      lim;
    logic [LIM_W-1:0]      frag_end;
    logic [LIM_W-1:0]      clip_end;
    logic [DEPTH_BITS-1:0] rd_depth;
    logic                  ram_we;
    logic [SITE_AW-1:0]    ram_waddr;
    logic [DEPTH_BITS-1:0] ram_wdata;
    logic [SITES_W:0]      rem_sh;
    logic                  take;
    logic [SITES_W-1:0]    n_rem;
    logic [DIVD_W-1:0]     n_quo;
    logic [MEAN_W-1:0]     n_mean;

    // Handshake decode.
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Register read-back.
    always_comb begin
        case (paddr[2])
            REG_TARGET: prdata = APB_DW'(r_target);
            REG_REGION: prdata = APB_DW'(r_region);
            default:    prdata = '0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_region <= REGION_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TARGET: r_target <= pwdata[TARGET_W-1:0];
                REG_REGION: r_region <= pwdata[REGION_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clip the fragment to the smaller of the region and the store size.
    always_comb begin
        lim = (LIM_W'(r_region) > LIM_W'(MAX_SITES)) ? LIM_W'(MAX_SITES) : LIM_W'(r_region);
        frag_end = LIM_W'(i_frag_start) + LIM_W'(i_frag_length);
        clip_end = (frag_end > lim) ? lim : frag_end;
    end

    // A read goes out each cycle while sites remain; the walk ends once the last
    // read-modify-write has retired.
    assign issue     = (r_state == S_RUN) && (r_addr < r_end);
    assign walk_done = (r_state == S_RUN) && !issue && !r_pend;

    // Write port: zero during the clearing pass, else the raised depth.
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_pend && (rd_depth != DEPTH_MAX);
            ram_waddr = r_waddr;
            ram_wdata = rd_depth + DEPTH_BITS'(1);
        end
    end

    rdca_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (MAX_SITES)
    ) u_site_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_addr[SITE_AW-1:0]),
        .o_rdata (rd_depth)
    );

    // One restoring division step.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        take   = rem_sh >= {1'b0, r_nonzero};
        n_rem  = take ? SITES_W'(rem_sh - {1'b0, r_nonzero}) : rem_sh[SITES_W-1:0];
        n_quo  = {r_quo[DIVD_W-2:0], take};
        if (r_nonzero == '0) begin
            n_mean = '0;
        end else if (|n_quo[DIVD_W-1:MEAN_W]) begin
            n_mean = MEAN_MAX;
        end else begin
            n_mean = n_quo[MEAN_W-1:0];
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_RUN;
            end
            S_RUN: begin
                if (walk_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        busy   = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
    end

    // Control registers: clearing sweep and read pipeline flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) r_clr <= r_clr + SITE_AW'(1);
            r_pend <= issue;
        end
    end

    // Totals and fragment count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_nonzero <= '0;
            r_frag    <= '0;
        end else begin
            if (accept && (r_frag != SUM_MAX)) r_frag <= r_frag + SUM_W'(1);
            if (r_pend && (r_state == S_RUN)) begin
                if ((rd_depth == '0) && (r_nonzero != SITES_MAX)) begin
                    r_nonzero <= r_nonzero + SITES_W'(1);
                end
                if ((rd_depth != DEPTH_MAX) && (r_total != SUM_MAX)) begin
                    r_total <= r_total + SUM_W'(1);
                end
            end
        end
    end

    // Site walk and divider datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= LIM_W'(i_frag_start);
            r_end  <= clip_end;
        end else if (issue) begin
            r_addr <= r_addr + LIM_W'(1);
        end
        r_waddr <= r_addr[SITE_AW-1:0];

        if (walk_done) begin
            r_rem <= '0;
            r_quo <= {r_total, {FRAC_W{1'b0}}};
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_LAST) begin
                r_mean <= n_mean;
                r_hit  <= (n_mean >= r_target);
            end
        end
    end

    // Result ports.
    assign o_depth_sum      = r_total;
    assign o_covered_sites  = r_nonzero;
    assign o_mean_depth     = r_mean;
    assign o_fragment_count = r_frag;
    assign o_target_reached = r_hit;

    // Checks.
    `RDCA_ASSERT_NEXT(a_div_to_done, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == DIV_LAST), o_done, "division end did not give a result")
    `RDCA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not raise busy")
    `RDCA_ASSERT_SAME(a_cover_le_sum, i_clk, i_rst_n, 1'b1, SUM_W'(r_nonzero) <= r_total, "covered sites exceed depth sum")
    `RDCA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held for more than one cycle")

endmodule

`default_nettype wire
